// File: rtl/scm_pkg.sv
// ----------------------------------------------------------------------------
// scm_pkg
// Shared widths, defaults and the cell control bundle for the covariance unit.
// ----------------------------------------------------------------------------
package scm_pkg;

    localparam int IN_W            = 28;   // Q4.24 return
    localparam int DEV_W           = IN_W + 1;
    localparam int PROD_W          = 2 * DEV_W;
    localparam int COV_W           = 64;   // Q16.48 result
    localparam int IDX_W           = 3;    // row / col port width
    localparam int NUM_IN          = 8;    // return fields on the input beat
    localparam int MAX_SAMPLES_DEF = 64;
    localparam int NUM_ASSETS_DEF  = 8;
    localparam int ACC_W_DEF       = PROD_W + $clog2(MAX_SAMPLES_DEF + 1);

    typedef struct packed {
        logic clear;       // zero the accumulator
        logic sum_x;       // add raw sample (mean pass)
        logic dev_en;      // register deviation
        logic mul_en;      // register product
        logic sum_prod;    // add product (covariance pass)
        logic shift_acc;   // move accumulators one cell down
        logic shift_mean;  // move means one cell down
    } t_cell_ctl;

endpackage

// File: rtl/scm_cell.sv
// ----------------------------------------------------------------------------
// scm_cell
// One asset lane: deviation, product and wide accumulator, plus the asset
// mean. Accumulators and means move toward cell 0 during drain.
// ----------------------------------------------------------------------------
module scm_cell #(
    parameter int ACC_W = scm_pkg::ACC_W_DEF
) (
    input  logic                              i_clk,
    input  scm_pkg::t_cell_ctl                i_ctl,
    input  logic signed [scm_pkg::IN_W-1:0]   i_x,
    input  logic signed [scm_pkg::DEV_W-1:0]  i_dev_a,
    input  logic signed [ACC_W-1:0]           i_acc_next,
    input  logic signed [scm_pkg::IN_W-1:0]   i_mean_next,
    output logic signed [ACC_W-1:0]           o_acc,
    output logic signed [scm_pkg::IN_W-1:0]   o_mean
);

    logic signed [ACC_W-1:0]            r_acc;
    logic signed [scm_pkg::IN_W-1:0]    r_mean;
    logic signed [scm_pkg::DEV_W-1:0]   r_dev;
    logic signed [scm_pkg::PROD_W-1:0]  r_prod;

    always_ff @(posedge i_clk) begin
        if (i_ctl.clear) begin
            r_acc <= '0;
        end else if (i_ctl.shift_acc) begin
            r_acc <= i_acc_next;
        end else if (i_ctl.sum_x) begin
            r_acc <= r_acc + ACC_W'(i_x);
        end else if (i_ctl.sum_prod) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
        if (i_ctl.dev_en) begin
            r_dev <= scm_pkg::DEV_W'(i_x) - scm_pkg::DEV_W'(r_mean);
        end
        if (i_ctl.mul_en) begin
            r_prod <= r_dev * i_dev_a;
        end
        if (i_ctl.shift_mean) begin
            r_mean <= i_mean_next;
        end
    end

    assign o_acc  = r_acc;
    assign o_mean = r_mean;

endmodule

// File: rtl/scm_div.sv
// ----------------------------------------------------------------------------
// scm_div
// Restoring divider, one quotient bit per cycle, rounds toward zero.
// Signed dividend, unsigned nonzero divisor.
// ----------------------------------------------------------------------------
module scm_div #(
    parameter int DVD_W = scm_pkg::ACC_W_DEF,
    parameter int DVS_W = $clog2(scm_pkg::MAX_SAMPLES_DEF + 1)
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0]        i_divisor,
    output logic                    o_done,
    output logic signed [DVD_W-1:0] o_quot
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    typedef enum logic [1:0] {D_IDLE, D_RUN, D_FIX} t_dstate;

    t_dstate          r_state;
    logic [DVD_W-1:0] r_mag;
    logic [DVS_W:0]   r_rem;
    logic [DVS_W-1:0] r_dvs;
    logic [CNT_W-1:0] r_cnt;
    logic             r_neg;
    logic [DVS_W:0]   rem_sh;
    logic             q_bit;
    logic [DVS_W:0]   rem_nx;

    always_comb begin
        rem_sh = {r_rem[DVS_W-1:0], r_mag[DVD_W-1]};
        q_bit  = (rem_sh >= {1'b0, r_dvs});
        rem_nx = q_bit ? (rem_sh - {1'b0, r_dvs}) : rem_sh;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
            o_done  <= 1'b0;
        end else begin
            o_done <= 1'b0;
            case (r_state)
                D_IDLE: begin
                    if (i_start) begin
                        r_neg   <= i_dividend[DVD_W-1];
                        r_mag   <= i_dividend[DVD_W-1] ? DVD_W'(-i_dividend)
                                                       : DVD_W'(i_dividend);
                        r_dvs   <= i_divisor;
                        r_rem   <= '0;
                        r_cnt   <= '0;
                        r_state <= D_RUN;
                    end
                end
                D_RUN: begin
                    r_rem <= rem_nx;
                    r_mag <= {r_mag[DVD_W-2:0], q_bit};
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(DVD_W - 1)) begin
                        r_state <= D_FIX;
                    end
                end
                D_FIX: begin
                    o_quot  <= r_neg ? -$signed(r_mag) : $signed(r_mag);
                    o_done  <= 1'b1;
                    r_state <= D_IDLE;
                end
                default: r_state <= D_IDLE;
            endcase
        end
    end

endmodule

// File: rtl/sample_covariance_matrix_unit.sv
// ----------------------------------------------------------------------------
// sample_covariance_matrix_unit
// Load: each accepted beat stores one sample vector until the memory is full.
// Compute, after the last beat: a mean pass, then one covariance pass per
// row; the shared serial divider sets the drain time. No new beat is
// taken while a batch is computed. Synchronous reset clears control state;
// the sample memory is not cleared.
// ----------------------------------------------------------------------------
module sample_covariance_matrix_unit #(
    parameter int MAX_SAMPLES = scm_pkg::MAX_SAMPLES_DEF,
    parameter int NUM_ASSETS  = scm_pkg::NUM_ASSETS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic signed [scm_pkg::IN_W-1:0]     i_return_0,
    input  logic signed [scm_pkg::IN_W-1:0]     i_return_1,
    input  logic signed [scm_pkg::IN_W-1:0]     i_return_2,
    input  logic signed [scm_pkg::IN_W-1:0]     i_return_3,
    input  logic signed [scm_pkg::IN_W-1:0]     i_return_4,
    input  logic signed [scm_pkg::IN_W-1:0]     i_return_5,
    input  logic signed [scm_pkg::IN_W-1:0]     i_return_6,
    input  logic signed [scm_pkg::IN_W-1:0]     i_return_7,
    input  logic                                i_final_sample,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [scm_pkg::IDX_W-1:0]           o_row,
    output logic [scm_pkg::IDX_W-1:0]           o_col,
    output logic signed [scm_pkg::COV_W-1:0]    o_covariance,
    output logic signed [scm_pkg::IN_W-1:0]     o_row_mean,
    output logic                                o_overflowed,
    output logic                                o_end_of_matrix
);

    localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
    localparam int ADDR_W = $clog2(MAX_SAMPLES);
    localparam int ACC_W  = scm_pkg::PROD_W + CNT_W;
    localparam int MEM_W  = NUM_ASSETS * scm_pkg::IN_W;

    typedef enum logic [2:0] {S_LOAD, S_ISSUE, S_FLUSH, S_DSTART, S_DWAIT, S_EMIT} t_state;

    t_state                            r_state, n_state;
    logic [CNT_W-1:0]                  r_count, n_count;
    logic                              r_drop, n_drop;
    logic [CNT_W-1:0]                  r_k, n_k;
    logic [scm_pkg::IDX_W-1:0]         r_row, n_row;
    logic [scm_pkg::IDX_W-1:0]         r_col, n_col;
    logic                              r_pass_mean, n_pass_mean;
    logic                              r_p1, r_p2, r_p3;
    logic                              n_clear;
    logic                              n_emit;

    logic [MEM_W-1:0]                  mem [MAX_SAMPLES];
    logic [MEM_W-1:0]                  r_rdata;
    logic [MEM_W-1:0]                  wr_word;
    logic signed [scm_pkg::IN_W-1:0]   ret_in [scm_pkg::NUM_IN];
    logic signed [scm_pkg::DEV_W-1:0]  r_dev_a;
    logic signed [scm_pkg::IN_W-1:0]   x_a;
    logic signed [scm_pkg::IN_W-1:0]   mean_a;

    logic signed [ACC_W-1:0]           cell_acc  [NUM_ASSETS];
    logic signed [scm_pkg::IN_W-1:0]   cell_mean [NUM_ASSETS];
    scm_pkg::t_cell_ctl                ctl;

    logic                              div_done;
    logic signed [ACC_W-1:0]           div_quot;
    logic                              in_acc;
    logic                              out_free;

    assign ret_in[0] = i_return_0;
    assign ret_in[1] = i_return_1;
    assign ret_in[2] = i_return_2;
    assign ret_in[3] = i_return_3;
    assign ret_in[4] = i_return_4;
    assign ret_in[5] = i_return_5;
    assign ret_in[6] = i_return_6;
    assign ret_in[7] = i_return_7;

    always_comb begin
        for (int a = 0; a < NUM_ASSETS; a++) begin
            wr_word[a*scm_pkg::IN_W +: scm_pkg::IN_W] = ret_in[a];
        end
    end

    assign o_in_stall = (r_state != S_LOAD);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign out_free   = !o_out_valid || !i_out_stall;

    // sample memory
    always_ff @(posedge i_clk) begin
        if (in_acc && (r_count < CNT_W'(MAX_SAMPLES))) begin
            mem[r_count[ADDR_W-1:0]] <= wr_word;
        end
        r_rdata <= mem[r_k[ADDR_W-1:0]];
    end

    // row asset lane and mean, broadcast to every cell
    always_comb begin
        x_a    = '0;
        mean_a = '0;
        for (int a = 0; a < NUM_ASSETS; a++) begin
            if (r_row == scm_pkg::IDX_W'(a)) begin
                x_a    = r_rdata[a*scm_pkg::IN_W +: scm_pkg::IN_W];
                mean_a = cell_mean[a];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_p1) begin
            r_dev_a <= scm_pkg::DEV_W'(x_a) - scm_pkg::DEV_W'(mean_a);
        end
    end

    always_comb begin
        ctl.clear      = n_clear;
        ctl.sum_x      = r_p1 && r_pass_mean;
        ctl.dev_en     = r_p1 && !r_pass_mean;
        ctl.mul_en     = r_p2;
        ctl.sum_prod   = r_p3;
        ctl.shift_acc  = (r_state == S_DSTART);
        ctl.shift_mean = (r_state == S_DWAIT) && div_done && r_pass_mean;
    end

    for (genvar g = 0; g < NUM_ASSETS; g++) begin : g_cell
        logic signed [ACC_W-1:0]         acc_next;
        logic signed [scm_pkg::IN_W-1:0] mean_next;
        if (g == NUM_ASSETS - 1) begin : g_top
            assign acc_next  = '0;
            assign mean_next = scm_pkg::IN_W'(div_quot);
        end else begin : g_mid
            assign acc_next  = cell_acc[g+1];
            assign mean_next = cell_mean[g+1];
        end
        scm_cell #(.ACC_W(ACC_W)) u_cell (
            .i_clk       (i_clk),
            .i_ctl       (ctl),
            .i_x         (r_rdata[g*scm_pkg::IN_W +: scm_pkg::IN_W]),
            .i_dev_a     (r_dev_a),
            .i_acc_next  (acc_next),
            .i_mean_next (mean_next),
            .o_acc       (cell_acc[g]),
            .o_mean      (cell_mean[g])
        );
    end

    scm_div #(.DVD_W(ACC_W), .DVS_W(CNT_W)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == S_DSTART),
        .i_dividend (cell_acc[0]),
        .i_divisor  (r_count),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_drop      = r_drop;
        n_k         = r_k;
        n_row       = r_row;
        n_col       = r_col;
        n_pass_mean = r_pass_mean;
        n_clear     = 1'b0;
        n_emit      = 1'b0;
        case (r_state)
            S_LOAD: begin
                if (in_acc) begin
                    if (r_count < CNT_W'(MAX_SAMPLES)) begin
                        n_count = r_count + 1'b1;
                    end else begin
                        n_drop = 1'b1;
                    end
                    if (i_final_sample) begin
                        n_pass_mean = 1'b1;
                        n_row       = '0;
                        n_k         = '0;
                        n_clear     = 1'b1;
                        n_state     = S_ISSUE;
                    end
                end
            end
            S_ISSUE: begin
                n_k = r_k + 1'b1;
                if (r_k == r_count - 1'b1) begin
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: begin
                if (!r_p1 && !r_p2 && !r_p3) begin
                    n_col   = '0;
                    n_state = S_DSTART;
                end
            end
            S_DSTART: begin
                n_state = S_DWAIT;
            end
            S_DWAIT: begin
                if (div_done) begin
                    if (r_pass_mean) begin
                        if (r_col == scm_pkg::IDX_W'(NUM_ASSETS - 1)) begin
                            n_pass_mean = 1'b0;
                            n_row       = '0;
                            n_k         = '0;
                            n_clear     = 1'b1;
                            n_state     = S_ISSUE;
                        end else begin
                            n_col   = r_col + 1'b1;
                            n_state = S_DSTART;
                        end
                    end else begin
                        n_state = S_EMIT;
                    end
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_emit = 1'b1;
                    if (r_col != scm_pkg::IDX_W'(NUM_ASSETS - 1)) begin
                        n_col   = r_col + 1'b1;
                        n_state = S_DSTART;
                    end else if (r_row != scm_pkg::IDX_W'(NUM_ASSETS - 1)) begin
                        n_row   = r_row + 1'b1;
                        n_k     = '0;
                        n_clear = 1'b1;
                        n_state = S_ISSUE;
                    end else begin
                        // batch done, start a new one
                        n_count = '0;
                        n_drop  = 1'b0;
                        n_state = S_LOAD;
                    end
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_count     <= '0;
            r_drop      <= 1'b0;
            r_k         <= '0;
            r_row       <= '0;
            r_col       <= '0;
            r_pass_mean <= 1'b0;
            r_p1        <= 1'b0;
            r_p2        <= 1'b0;
            r_p3        <= 1'b0;
            o_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_drop      <= n_drop;
            r_k         <= n_k;
            r_row       <= n_row;
            r_col       <= n_col;
            r_pass_mean <= n_pass_mean;
            r_p1        <= (r_state == S_ISSUE);
            r_p2        <= r_p1 && !r_pass_mean;
            r_p3        <= r_p2;
            if (n_emit) begin
                o_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    // hold the result beat until taken
    always_ff @(posedge i_clk) begin
        if (n_emit) begin
            o_row           <= r_row;
            o_col           <= r_col;
            o_covariance    <= scm_pkg::COV_W'(div_quot);
            o_row_mean      <= mean_a;
            o_overflowed    <= r_drop;
            o_end_of_matrix <= (r_row == scm_pkg::IDX_W'(NUM_ASSETS - 1))
                            && (r_col == scm_pkg::IDX_W'(NUM_ASSETS - 1));
        end
    end

endmodule
